[rtl/llbr_pkg.sv]
package llbr_pkg;

  // Default sample width in bits
  localparam int VALUE_WIDTH_DEF = 32;

  // Granularity register width; also bounds the sub-bucket index
  localparam int GRAN_W = 8;

  // Octave / granularity divider: dividend bits retired per stage
  localparam int DIV_STEP = 8;

  // Position divider: quotient bits retired per stage
  localparam int MOD_STEP = 2;

  // Round a bit count up to whole bytes
  function automatic int byte_pad(input int bits);
    return ((bits + 7) >> 3) << 3;
  endfunction

endpackage

[rtl/log_linear_bucket_range.sv]
// Log-linear histogram bucket locator. Each signed sample on the in_ stream
// gives one item on the out_ stream: the low and high ends of the bucket that
// holds it, and a flag set when the bucket holds a single value. Each
// power-of-two octave of the magnitude is split into `granularity` sub-buckets
// (written on the cfg_ port while the block is idle; 0 turns bucketing off and
// every bucket becomes the sample itself). Small sub-buckets come first, then
// sub-buckets one value wider, so the octave is covered exactly. Negative
// samples give the mirrored range, and the most negative value is saturated
// to one above it. The block takes one item per clock while the output is not
// stalled. Its depth is set by the two dividers: octave width over granularity
// at 8 dividend bits per stage, then offset over sub-bucket width at 2 quotient
// bits per stage. Stalls on the output fill bubbles first, so in_tready stays
// high while any stage is free.
module log_linear_bucket_range #(
  parameter int VALUE_WIDTH = llbr_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  // configuration: granularity
  input  logic                                          cfg_tvalid,
  output logic                                          cfg_tready,
  input  logic [llbr_pkg::GRAN_W-1:0]                   cfg_tdata,
  // in_tdata: sample_value
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  input  logic [llbr_pkg::byte_pad(VALUE_WIDTH)-1:0]    in_tdata,
  // out_tdata: bucket_low, bucket_high (low bits first)
  // out_tuser: single_value
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  output logic [llbr_pkg::byte_pad(2*VALUE_WIDTH)-1:0]  out_tdata,
  output logic [0:0]                                    out_tuser
);
  import llbr_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int MW    = VALUE_WIDTH - 1;          // magnitude width
  localparam int GW    = GRAN_W;
  localparam int OUT_W = byte_pad(2 * VALUE_WIDTH);
  localparam int NQ1   = (MW + DIV_STEP - 1) / DIV_STEP;
  localparam int PADW  = NQ1 * DIV_STEP;
  localparam int NQ2   = GRAN_W / MOD_STEP;

  // stage map
  localparam int ST_MAG  = 0;
  localparam int ST_LEAD = 1;
  localparam int ST_DIV1 = 2;
  localparam int ST_MUL  = ST_DIV1 + NQ1;
  localparam int ST_SEL  = ST_MUL + 1;
  localparam int ST_DIV2 = ST_SEL + 1;
  localparam int ST_LOHI = ST_DIV2 + NQ2;
  localparam int ST_OUT  = ST_LOHI + 1;
  localparam int NST     = ST_OUT + 1;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
    logic [GW-1:0] g;
  } mag_st_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
    logic [GW-1:0] g;
    logic          byp;
    logic [MW-1:0] d;
  } lead_st_t;

  typedef struct packed {
    logic [MW-1:0]   mag;
    logic            neg;
    logic [GW-1:0]   g;
    logic            byp;
    logic [MW-1:0]   d;
    logic [PADW-1:0] dsh;   // dividend bits still to retire
    logic [PADW-1:0] quo;
    logic [GW-1:0]   rem;
  } div1_st_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
    logic          byp;
    logic [MW-1:0] off;
    logic [MW-1:0] tsm;
    logic [MW-1:0] sml;
  } mul_st_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
    logic          byp;
    logic [MW-1:0] rem;
    logic [MW-1:0] dvs;
  } mod_st_t;

  typedef struct packed {
    logic          neg;
    logic [MW-1:0] lo;
    logic [MW-1:0] hi;
  } lohi_st_t;

  logic [GW-1:0]  gran_r;
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_in;
  logic [NST-1:0] en;

  mag_st_t  mag_r,  mag_nxt;
  lead_st_t lead_r, lead_nxt;
  div1_st_t div1_r [NQ1];
  div1_st_t div1_nxt [NQ1];
  mul_st_t  mul_r,  mul_nxt;
  mod_st_t  sel_r,  sel_nxt;
  mod_st_t  div2_r [NQ2];
  mod_st_t  div2_nxt [NQ2];
  lohi_st_t lohi_r, lohi_nxt;

  logic [VW-1:0] lo_r, lo_nxt;
  logic [VW-1:0] hi_r, hi_nxt;
  logic          single_r, single_nxt;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gran_r <= '0;
    end else if (cfg_tvalid) begin
      gran_r <= cfg_tdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign v_in      = {v_r[NST-2:0], in_tvalid};
  assign in_tready = en[ST_MAG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_in & en) | (v_r & ~en);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: magnitude with saturation of the most negative value.
  // Granularity is captured with the item.
  // ---------------------------------------------------------------------------
  logic [VW-1:0] smp;
  logic [VW-1:0] smp_neg;

  always_comb begin
    smp         = in_tdata[VW-1:0];
    smp_neg     = ~smp + VW'(1);
    mag_nxt.neg = smp[VW-1];
    mag_nxt.g   = gran_r;
    if (smp == {1'b1, {MW{1'b0}}}) begin
      mag_nxt.mag = {MW{1'b1}};
    end else if (smp[VW-1]) begin
      mag_nxt.mag = smp_neg[MW-1:0];
    end else begin
      mag_nxt.mag = smp[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      mag_r <= mag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: octave base d = 2^floor(log2(mag)), bypass decision
  // ---------------------------------------------------------------------------
  logic [MW-1:0] smear;

  always_comb begin
    smear = mag_r.mag;
    for (int s = 1; s < MW; s = s << 1) begin
      smear = smear | (smear >> s);
    end
    lead_nxt.mag = mag_r.mag;
    lead_nxt.neg = mag_r.neg;
    lead_nxt.g   = mag_r.g;
    lead_nxt.d   = smear & ~(smear >> 1);
    // zero sample, bucketing off, or octave no wider than granularity
    lead_nxt.byp = (mag_r.mag == '0) || (mag_r.g == '0) ||
                   ({{GW{1'b0}}, lead_nxt.d} <= {{MW{1'b0}}, mag_r.g});
  end

  always_ff @(posedge clk) begin
    if (en[ST_LEAD]) begin
      lead_r <= lead_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages: restoring division d / g, DIV_STEP dividend bits per stage.
  // Quotient is the small sub-bucket width, remainder the count of wide ones.
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < NQ1; s++) begin : g_div1
    div1_st_t    src;
    logic [GW:0] trial;
    logic        hit;

    if (s == 0) begin : g_first
      always_comb begin
        src.mag = lead_r.mag;
        src.neg = lead_r.neg;
        src.g   = lead_r.g;
        src.byp = lead_r.byp;
        src.d   = lead_r.d;
        src.dsh = PADW'(lead_r.d);
        src.quo = '0;
        src.rem = '0;
      end
    end else begin : g_rest
      assign src = div1_r[s-1];
    end

    always_comb begin
      div1_nxt[s] = src;
      trial       = '0;
      hit         = 1'b0;
      for (int j = 0; j < DIV_STEP; j++) begin
        trial           = {div1_nxt[s].rem, div1_nxt[s].dsh[PADW-1]};
        div1_nxt[s].dsh = div1_nxt[s].dsh << 1;
        hit             = (trial >= {1'b0, div1_nxt[s].g});
        if (hit) begin
          trial = trial - {1'b0, div1_nxt[s].g};
        end
        div1_nxt[s].rem = trial[GW-1:0];
        div1_nxt[s].quo = {div1_nxt[s].quo[PADW-2:0], hit};
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV1+s]) begin
        div1_r[s] <= div1_nxt[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: span of the small sub-buckets and offset into the octave
  // ---------------------------------------------------------------------------
  logic [GW-1:0]    nsmall;
  logic [MW+GW-1:0] tsm_full;

  always_comb begin
    mul_nxt.mag = div1_r[NQ1-1].mag;
    mul_nxt.neg = div1_r[NQ1-1].neg;
    mul_nxt.byp = div1_r[NQ1-1].byp;
    mul_nxt.sml = div1_r[NQ1-1].quo[MW-1:0];
    mul_nxt.off = div1_r[NQ1-1].mag - div1_r[NQ1-1].d;
    nsmall      = div1_r[NQ1-1].g - div1_r[NQ1-1].rem;
    tsm_full    = {{MW{1'b0}}, nsmall} * {{GW{1'b0}}, mul_nxt.sml};
    mul_nxt.tsm = tsm_full[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      mul_r <= mul_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: pick the small or the wide region, set dividend and width
  // ---------------------------------------------------------------------------
  always_comb begin
    sel_nxt.mag = mul_r.mag;
    sel_nxt.neg = mul_r.neg;
    sel_nxt.byp = mul_r.byp;
    if (mul_r.off < mul_r.tsm) begin
      sel_nxt.rem = mul_r.off;
      sel_nxt.dvs = mul_r.sml;
    end else begin
      sel_nxt.rem = mul_r.off - mul_r.tsm;
      sel_nxt.dvs = mul_r.sml + MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SEL]) begin
      sel_r <= sel_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages: offset mod width. Quotient stays below the granularity, so GW
  // restoring steps suffice; MOD_STEP of them per stage.
  // ---------------------------------------------------------------------------
  for (genvar t = 0; t < NQ2; t++) begin : g_div2
    mod_st_t          src;
    logic [MW+GW-1:0] dvs_sh;

    if (t == 0) begin : g_first
      assign src = sel_r;
    end else begin : g_rest
      assign src = div2_r[t-1];
    end

    always_comb begin
      div2_nxt[t] = src;
      dvs_sh      = '0;
      for (int j = 0; j < MOD_STEP; j++) begin
        dvs_sh = {{GW{1'b0}}, src.dvs} << (GW - 1 - (t * MOD_STEP + j));
        if ({{GW{1'b0}}, div2_nxt[t].rem} >= dvs_sh) begin
          div2_nxt[t].rem = div2_nxt[t].rem - dvs_sh[MW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV2+t]) begin
        div2_r[t] <= div2_nxt[t];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage: bucket ends on the magnitude
  // ---------------------------------------------------------------------------
  always_comb begin
    lohi_nxt.neg = div2_r[NQ2-1].neg;
    if (div2_r[NQ2-1].byp) begin
      lohi_nxt.lo = div2_r[NQ2-1].mag;
      lohi_nxt.hi = div2_r[NQ2-1].mag;
    end else begin
      lohi_nxt.lo = div2_r[NQ2-1].mag - div2_r[NQ2-1].rem;
      lohi_nxt.hi = div2_r[NQ2-1].mag - div2_r[NQ2-1].rem +
                    div2_r[NQ2-1].dvs - MW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_LOHI]) begin
      lohi_r <= lohi_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: mirror for negative samples
  // ---------------------------------------------------------------------------
  always_comb begin
    single_nxt = (lohi_r.lo == lohi_r.hi);
    if (lohi_r.neg) begin
      lo_nxt = ~{1'b0, lohi_r.lo} + VW'(1);
      hi_nxt = ~{1'b0, lohi_r.hi} + VW'(1);
    end else begin
      lo_nxt = {1'b0, lohi_r.lo};
      hi_nxt = {1'b0, lohi_r.hi};
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      single_r <= single_nxt;
    end
  end

  assign out_tvalid = v_r[ST_OUT];
  assign out_tdata  = OUT_W'({hi_r, lo_r});
  assign out_tuser  = single_r;

`ifndef SYNTHESIS
  // both ends of a bucket lie on the same side of zero
  a_same_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (lo_r[VW-1] == hi_r[VW-1]))
    else $error("bucket ends differ in sign");

  // non-negative bucket is ordered low to high
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !lo_r[VW-1]) |-> (lo_r <= hi_r))
    else $error("bucket low above bucket high");

  // an empty output stage means every stage can load
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output stage empty");

  // flag follows the ends it describes
  a_single_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (lo_r == hi_r)))
    else $error("single-value flag mismatch");
`endif

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW          = llbr_pkg::VALUE_WIDTH_DEF;
  localparam int GW          = llbr_pkg::GRAN_W;
  localparam int DRAIN_SLACK = 24;      // pipeline is 14 deep at 32 bits
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENTS    = 9;
  localparam int SEG_ITEMS   = 128;
  localparam int NUM_ROWS    = 23;

  // one bucket range as the block reports it
  typedef struct packed {
    logic [VW-1:0] low;
    logic [VW-1:0] high;
    logic          one_value;
  } bucket_t;

  // directed row: granularity to run under, sample, and optionally the range
  // typed in by hand (otherwise the predictor supplies it)
  typedef struct packed {
    logic [GW-1:0] gran;
    logic [VW-1:0] sample;
    logic          typed;
    logic [VW-1:0] low;
    logic [VW-1:0] high;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_tvalid;
  logic               cfg_tready;
  logic [GW-1:0]      cfg_tdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [VW-1:0]      in_tdata;    // sample_value
  logic               out_tvalid;
  logic               out_tready;
  logic [2*VW-1:0]    out_tdata;   // bucket_low, bucket_high
  logic [0:0]         out_tuser;   // single_value

  log_linear_bucket_range #(.VALUE_WIDTH(VW)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow of the granularity register and the ranges still owed by the block
  logic [GW-1:0] granularity = '0;
  bucket_t       expected_buckets[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;     // long receiver hold-off, counted down below
  int cycles        = 0;
  int mismatches    = 0;
  int samples_sent  = 0;
  int ranges_seen   = 0;
  int gran_writes   = 0;

  logic [GW-1:0] seg_gran [SEGMENTS];

  // Hand-checked rows: reset value (no bucketing), extremes of the sample,
  // granularity 1, 255 and 128, narrow octaves and the saturated most negative
  // value. Rows with typed clear go to the predictor.
  row_t directed_rows [NUM_ROWS] = '{
    '{8'd0,   32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{8'd0,   32'h0000_0001, 1'b1, 32'h0000_0001, 32'h0000_0001},
    '{8'd0,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{8'd0,   32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{8'd0,   32'h8000_0000, 1'b1, 32'h8000_0001, 32'h8000_0001},
    '{8'd0,   32'h0000_3039, 1'b1, 32'h0000_3039, 32'h0000_3039},
    '{8'd1,   32'h0000_0001, 1'b1, 32'h0000_0001, 32'h0000_0001},
    '{8'd1,   32'h0000_0005, 1'b1, 32'h0000_0004, 32'h0000_0007},
    '{8'd1,   32'hFFFF_FFFB, 1'b1, 32'hFFFF_FFFC, 32'hFFFF_FFF9},
    '{8'd1,   32'h7FFF_FFFF, 1'b1, 32'h4000_0000, 32'h7FFF_FFFF},
    '{8'd1,   32'h8000_0000, 1'b1, 32'hC000_0000, 32'h8000_0001},
    '{8'd255, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{8'd255, 32'h0000_0064, 1'b1, 32'h0000_0064, 32'h0000_0064},
    '{8'd255, 32'h0000_00FF, 1'b1, 32'h0000_00FF, 32'h0000_00FF},
    '{8'd255, 32'h0000_0100, 1'b0, 32'h0,         32'h0},
    '{8'd255, 32'h7FFF_FFFF, 1'b0, 32'h0,         32'h0},
    '{8'd255, 32'h8000_0000, 1'b0, 32'h0,         32'h0},
    '{8'd3,   32'h0000_0006, 1'b0, 32'h0,         32'h0},
    '{8'd3,   32'h5555_5555, 1'b0, 32'h0,         32'h0},
    '{8'd3,   32'hAAAA_AAAA, 1'b0, 32'h0,         32'h0},
    '{8'd3,   32'hFFFF_FFF9, 1'b0, 32'h0,         32'h0},
    '{8'd128, 32'h0000_0080, 1'b1, 32'h0000_0080, 32'h0000_0080},
    '{8'd128, 32'h0000_017F, 1'b0, 32'h0,         32'h0}
  };

  // Bucket range for one sample: octave [2^k, 2^(k+1)-1] of the magnitude is
  // cut into gran pieces, narrow ones (octave/gran wide) first, then pieces
  // one wider. Negative samples mirror the range.
  function automatic bucket_t locate_bucket(input logic [VW-1:0] sample,
                                            input logic [GW-1:0] gran);
    logic          neg;
    logic [VW-1:0] neg_sample;
    logic [63:0]   mag, octave, step, n_wide, narrow_span, offset, lo, hi;
    int            k;
    bucket_t       res;
    neg = sample[VW-1];
    if (sample == {1'b1, {(VW-1){1'b0}}})
      mag = {1'b0, {(VW-1){1'b1}}};     // saturate most negative value
    else if (neg) begin
      neg_sample = -sample;             // negate at sample width
      mag = 64'(neg_sample);
    end else
      mag = 64'(sample);
    if (mag == 0 || gran == 0) begin
      lo = mag;
      hi = mag;
    end else begin
      k = 0;
      for (int b = 0; b < VW; b++)
        if (mag[b]) k = b;
      octave = 64'd1 << k;
      if (octave <= 64'(gran)) begin
        // octave too narrow to split
        lo = mag;
        hi = mag;
      end else begin
        step        = octave / gran;
        n_wide      = octave - step * gran;
        narrow_span = (64'(gran) - n_wide) * step;
        offset      = mag - octave;
        if (offset < narrow_span) begin
          lo = octave + offset - offset % step;
          hi = lo + step - 1;
        end else begin
          offset = offset - narrow_span;
          lo = octave + narrow_span + offset - offset % (step + 1);
          hi = lo + step;
        end
      end
    end
    if (neg) begin
      lo = -lo;
      hi = -hi;
    end
    res.low       = lo[VW-1:0];
    res.high      = hi[VW-1:0];
    res.one_value = (res.low == res.high);
    return res;
  endfunction

  // Random sample: full-range words, small magnitudes, octave edges, the
  // extremes, and random points inside a random octave; mostly either sign.
  function automatic logic [VW-1:0] pick_sample();
    logic [VW-1:0] v;
    int            k;
    logic          may_negate;
    may_negate = 1'b1;
    case ($urandom_range(9))
      0, 1, 2: begin
        v = $urandom;
        may_negate = 1'b0;
      end
      3, 4: v = $urandom_range(300);
      5: begin
        k = $urandom_range(30);
        case ($urandom_range(2))
          0:       v = (32'd1 << k) - 1;
          1:       v = 32'd1 << k;
          default: v = (32'd1 << (k + 1)) - 1;
        endcase
      end
      6: begin
        may_negate = 1'b0;
        case ($urandom_range(2))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          default: v = 32'h0;
        endcase
      end
      default: begin
        k = $urandom_range(30);
        v = (32'd1 << k) | ($urandom & ((32'd1 << k) - 1));
      end
    endcase
    if (may_negate && $urandom_range(1))
      v = -v;
    return v;
  endfunction

  // Offer one sample, after a random idle gap; expectation is queued at the
  // edge where the item is taken.
  task automatic offer_sample(input logic [VW-1:0] value, input bucket_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20)
      gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    expected_buckets.push_back(want);
    samples_sent++;
  endtask

  // Stop offering and wait until every owed range is back, plus slack.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_buckets.size() != 0)
      @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Granularity only changes with the pipeline empty.
  task automatic write_granularity(input logic [GW-1:0] g);
    drain_results();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= g;
    @(posedge clk);
    while (!cfg_tready)
      @(posedge clk);
    cfg_tvalid  <= 1'b0;
    granularity = g;
    gran_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random backpressure, or a long hold-off when requested.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every taken item must match the oldest owed range.
  always @(posedge clk) begin : check_ranges
    bucket_t want;
    if (rst_n && out_tvalid && out_tready) begin
      ranges_seen++;
      if (expected_buckets.size() == 0) begin
        $display("%0t: unexpected result low %h high %h single %b", $time,
                 out_tdata[VW-1:0], out_tdata[2*VW-1:VW], out_tuser[0]);
        mismatches++;
      end else begin
        want = expected_buckets.pop_front();
        if (out_tdata[VW-1:0] !== want.low) begin
          $display("%0t: bucket_low expected %h, got %h", $time,
                   want.low, out_tdata[VW-1:0]);
          mismatches++;
        end
        if (out_tdata[2*VW-1:VW] !== want.high) begin
          $display("%0t: bucket_high expected %h, got %h", $time,
                   want.high, out_tdata[2*VW-1:VW]);
          mismatches++;
        end
        if (out_tuser[0] !== want.one_value) begin
          $display("%0t: single_value expected %b, got %b", $time,
                   want.one_value, out_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results owed", $time, expected_buckets.size());
      $display("** log_linear_bucket_range: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VW-1:0] sample;
    bucket_t       want;
    rst_n      = 1'b0;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;

    // granularity per random segment: extremes, small splits, random values
    seg_gran[0] = 8'd1;
    seg_gran[1] = 8'd255;
    seg_gran[2] = 8'($urandom_range(2, 20));
    seg_gran[3] = 8'd2;
    seg_gran[4] = 8'd0;
    seg_gran[5] = 8'($urandom_range(21, 254));
    seg_gran[6] = 8'd128;
    seg_gran[7] = 8'($urandom_range(4, 64));
    seg_gran[8] = 8'd3;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; the first ones run on the reset granularity
    send_idle_pct = 37;
    recv_idle_pct = 60;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].gran != granularity)
        write_granularity(directed_rows[r].gran);
      if (directed_rows[r].typed) begin
        want.low       = directed_rows[r].low;
        want.high      = directed_rows[r].high;
        want.one_value = (directed_rows[r].low == directed_rows[r].high);
      end else begin
        want = locate_bucket(directed_rows[r].sample, granularity);
      end
      offer_sample(directed_rows[r].sample, want);
    end

    // random segments: sender/receiver idling swaps after three segments, and the last three run with no idling
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_granularity(seg_gran[seg]);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // long output hold-off while input keeps coming: pipeline fills
        if (seg == 6 && n == 20)
          stall_left = 250;
        // sender pause until everything is back
        if (seg == 7 && n == 64)
          drain_results();
        sample = pick_sample();
        offer_sample(sample, locate_bucket(sample, granularity));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_buckets.size() != 0)
      @(posedge clk);
    repeat (2 * DRAIN_SLACK) @(posedge clk);

    $display("Ran %0d samples, %0d ranges checked, %0d granularity writes (0, 1, 2, 3,",
             samples_sent, ranges_seen, gran_writes);
    $display("128, 255 and random), with idling on both sides and a long output stall.");
    if (mismatches == 0) begin
      $display("** log_linear_bucket_range: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** log_linear_bucket_range: FAILED **");
    end
    $finish;
  end

endmodule
